>>> src/obbo_pkg.sv
package obbo_pkg;

  // Coordinate width (signed Q15.8 at the default); sizes are one bit narrower
  localparam int COORD_W = 24;
  localparam int SIZE_W  = COORD_W - 1;
  localparam int TRIG_W  = 16;
  localparam int GATE_W  = 46;
  localparam int MISS_W  = 9;
  localparam int LIMIT_W = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(25);
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(16384);

  // Request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic        [SIZE_W-1:0]  size_x;
    logic        [SIZE_W-1:0]  size_y;
    logic        [SIZE_W-1:0]  size_z;
    logic signed [TRIG_W-1:0]  axis_cos;
    logic signed [TRIG_W-1:0]  axis_sin;
  } in_req_t;

  typedef struct packed {
    logic overlap;
    logic out_of_range;
    logic search_done;
  } out_rsp_t;

  // One box with its heading already clamped to +-1.0
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic        [SIZE_W-1:0]  sx;
    logic        [SIZE_W-1:0]  sy;
    logic        [SIZE_W-1:0]  sz;
    logic signed [TRIG_W-1:0]  cosv;
    logic signed [TRIG_W-1:0]  sinv;
  } box_t;

  // Engine verdict on one candidate
  typedef struct packed {
    logic overlap;
    logic out_of_range;
  } eng_rsp_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_RUN,
    TS_QUICK
  } top_state_t;

  typedef enum logic [2:0] {
    ES_IDLE,
    ES_MUL,
    ES_ACC,
    ES_CHK,
    ES_DONE
  } eng_state_t;

  function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [TRIG_W-1:0] t);
    logic signed [TRIG_W-1:0] r;
    r = t;
    if (t > TRIG_ONE) r = TRIG_ONE;
    if (t < -TRIG_ONE) r = -TRIG_ONE;
    return r;
  endfunction

  function automatic box_t to_box(input in_req_t q);
    box_t b;
    b.cx   = q.center_x;
    b.cy   = q.center_y;
    b.cz   = q.center_z;
    b.sx   = q.size_x;
    b.sy   = q.size_y;
    b.sz   = q.size_z;
    b.cosv = clamp_trig(q.axis_cos);
    b.sinv = clamp_trig(q.axis_sin);
    return b;
  endfunction

endpackage

>>> src/obbo_sat_engine.sv
module obbo_sat_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          load,
  input  obbo_pkg::box_t                cand_i,
  input  obbo_pkg::box_t                ref_i,
  input  logic [obbo_pkg::GATE_W-1:0]   gate_i,
  input  logic                          take,
  output logic                          done,
  output obbo_pkg::eng_rsp_t            rsp,
  output logic [obbo_pkg::GATE_W-1:0]   gate_o
);

  localparam int W   = obbo_pkg::COORD_W;
  localparam int SW  = obbo_pkg::SIZE_W;
  localparam int XW  = W + 1;
  localparam int YW  = (W + 1 > 31) ? W + 1 : 31;
  localparam int PW  = XW + YW;
  localparam int AW  = PW + 1;
  localparam int RW  = W + 31;
  localparam int QW  = 2 * W + 2;
  localparam int CW  = (QW > obbo_pkg::GATE_W) ? QW : obbo_pkg::GATE_W;
  localparam int ZW  = W + 2;
  localparam int TW  = obbo_pkg::TRIG_W;

  localparam logic [2:0] GRP_DIST = 3'd0;
  localparam logic [2:0] GRP_LAST = 3'd4;
  localparam logic [3:0] STEP_DIST_LAST = 4'd2;
  localparam logic [3:0] STEP_AXIS_LAST = 4'd13;

  obbo_pkg::eng_state_t state_r, state_nxt;

  logic [2:0]            grp_r, grp_nxt;
  logic [3:0]            step_r, step_nxt;
  logic                  load_r;
  obbo_pkg::box_t        cand_r;
  logic signed [W:0]     dx_r, dy_r, dz_r;
  logic [SW-1:0]         m_r;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic signed [AW-1:0]  a_r, a_nxt, t_r, t_nxt;
  logic [RW-1:0]         r_r, r_nxt;
  logic [QW-1:0]         q_r, q_nxt;
  logic [obbo_pkg::GATE_W-1:0] gate_r, gate_nxt;
  obbo_pkg::eng_rsp_t    rsp_r, rsp_nxt;

  logic signed [XW-1:0]  x_mul;
  logic signed [YW-1:0]  y_mul;
  logic signed [TW-1:0]  ux, uy;
  logic signed [AW-1:0]  t_abs, a_abs;
  logic [W:0]            dz_abs;
  logic [RW-1:0]         lhs_ax;
  logic [ZW-1:0]         lhs_z, rhs_z;
  logic                  gate_miss;
  logic [SW-1:0]         m_in;

  // Largest dimension of an incoming reference
  always_comb begin
    m_in = cand_i.sx;
    if (cand_i.sy > m_in) m_in = cand_i.sy;
    if (cand_i.sz > m_in) m_in = cand_i.sz;
  end

  // Axis of the current group: both headings and their normals
  always_comb begin
    case (grp_r)
      3'd1: begin
        ux = ref_i.cosv;
        uy = ref_i.sinv;
      end
      3'd2: begin
        ux = -ref_i.sinv;
        uy = ref_i.cosv;
      end
      3'd3: begin
        ux = cand_r.cosv;
        uy = cand_r.sinv;
      end
      3'd4: begin
        ux = -cand_r.sinv;
        uy = cand_r.cosv;
      end
      default: begin
        ux = '0;
        uy = '0;
      end
    endcase
  end

  assign t_abs  = t_r[AW-1] ? -t_r : t_r;
  assign a_abs  = a_r[AW-1] ? -a_r : a_r;
  assign dz_abs = dz_r[W] ? (W+1)'(-dz_r) : (W+1)'(dz_r);

  // Operand select for the shared multiplier
  always_comb begin
    x_mul = '0;
    y_mul = '0;
    if (load_r) begin
      x_mul = XW'(m_r);
      y_mul = YW'(m_r);
    end else if (grp_r == GRP_DIST) begin
      case (step_r)
        4'd0: begin
          x_mul = XW'(dx_r);
          y_mul = YW'(dx_r);
        end
        4'd1: begin
          x_mul = XW'(dy_r);
          y_mul = YW'(dy_r);
        end
        default: begin
          x_mul = XW'(dz_r);
          y_mul = YW'(dz_r);
        end
      endcase
    end else begin
      case (step_r)
        4'd0:  begin x_mul = XW'(dx_r);        y_mul = YW'(ux); end
        4'd1:  begin x_mul = XW'(dy_r);        y_mul = YW'(uy); end
        4'd2:  begin x_mul = XW'(ref_i.cosv);  y_mul = YW'(ux); end
        4'd3:  begin x_mul = XW'(ref_i.sinv);  y_mul = YW'(uy); end
        4'd4:  begin x_mul = XW'(ref_i.sx);    y_mul = $signed(t_abs[YW-1:0]); end
        4'd5:  begin x_mul = XW'(ref_i.sinv);  y_mul = YW'(ux); end
        4'd6:  begin x_mul = XW'(ref_i.cosv);  y_mul = YW'(uy); end
        4'd7:  begin x_mul = XW'(ref_i.sy);    y_mul = $signed(t_abs[YW-1:0]); end
        4'd8:  begin x_mul = XW'(cand_r.cosv); y_mul = YW'(ux); end
        4'd9:  begin x_mul = XW'(cand_r.sinv); y_mul = YW'(uy); end
        4'd10: begin x_mul = XW'(cand_r.sx);   y_mul = $signed(t_abs[YW-1:0]); end
        4'd11: begin x_mul = XW'(cand_r.sinv); y_mul = YW'(ux); end
        4'd12: begin x_mul = XW'(cand_r.cosv); y_mul = YW'(uy); end
        default: begin x_mul = XW'(cand_r.sy); y_mul = $signed(t_abs[YW-1:0]); end
      endcase
    end
  end

  // Compare operands
  assign gate_miss = CW'(q_r) > CW'(gate_i);
  assign lhs_z     = ZW'(dz_abs) << 1;
  assign rhs_z     = ZW'(ref_i.sz) + ZW'(cand_r.sz);
  assign lhs_ax    = {a_abs[RW-16:0], 15'b0};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    a_nxt     = a_r;
    t_nxt     = t_r;
    r_nxt     = r_r;
    q_nxt     = q_r;
    gate_nxt  = gate_r;
    rsp_nxt   = rsp_r;
    case (state_r)
      obbo_pkg::ES_IDLE: begin
        if (start) begin
          state_nxt = obbo_pkg::ES_MUL;
          grp_nxt   = GRP_DIST;
          step_nxt  = '0;
          rsp_nxt   = '0;
        end
      end
      obbo_pkg::ES_MUL: begin
        prod_nxt  = x_mul * y_mul;
        state_nxt = obbo_pkg::ES_ACC;
      end
      obbo_pkg::ES_ACC: begin
        state_nxt = obbo_pkg::ES_MUL;
        step_nxt  = step_r + 4'd1;
        if (load_r) begin
          gate_nxt  = prod_r[obbo_pkg::GATE_W-1:0];
          state_nxt = obbo_pkg::ES_DONE;
        end else if (grp_r == GRP_DIST) begin
          q_nxt = (step_r == 4'd0) ? prod_r[QW-1:0] : q_r + prod_r[QW-1:0];
          if (step_r == STEP_DIST_LAST) state_nxt = obbo_pkg::ES_CHK;
        end else begin
          case (step_r)
            4'd0:                 a_nxt = AW'(prod_r);
            4'd1:                 a_nxt = a_r + AW'(prod_r);
            4'd2, 4'd8:           t_nxt = AW'(prod_r);
            4'd5, 4'd11:          t_nxt = -AW'(prod_r);
            4'd3, 4'd6, 4'd9, 4'd12: t_nxt = t_r + AW'(prod_r);
            4'd4:                 r_nxt = prod_r[RW-1:0];
            default:              r_nxt = r_r + prod_r[RW-1:0];
          endcase
          if (step_r == STEP_AXIS_LAST) state_nxt = obbo_pkg::ES_CHK;
        end
      end
      obbo_pkg::ES_CHK: begin
        step_nxt = '0;
        if (grp_r == GRP_DIST) begin
          // gate first, then vertical extents
          if (gate_miss) begin
            rsp_nxt.out_of_range = 1'b1;
            state_nxt = obbo_pkg::ES_DONE;
          end else if (lhs_z > rhs_z) begin
            state_nxt = obbo_pkg::ES_DONE;
          end else begin
            grp_nxt   = grp_r + 3'd1;
            state_nxt = obbo_pkg::ES_MUL;
          end
        end else begin
          if (lhs_ax > r_r) begin
            state_nxt = obbo_pkg::ES_DONE;
          end else if (grp_r == GRP_LAST) begin
            rsp_nxt.overlap = 1'b1;
            state_nxt = obbo_pkg::ES_DONE;
          end else begin
            grp_nxt   = grp_r + 3'd1;
            state_nxt = obbo_pkg::ES_MUL;
          end
        end
      end
      obbo_pkg::ES_DONE: begin
        if (take) state_nxt = obbo_pkg::ES_IDLE;
      end
      default: state_nxt = obbo_pkg::ES_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obbo_pkg::ES_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    grp_r  <= grp_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    a_r    <= a_nxt;
    t_r    <= t_nxt;
    r_r    <= r_nxt;
    q_r    <= q_nxt;
    gate_r <= gate_nxt;
    rsp_r  <= rsp_nxt;
    if (state_r == obbo_pkg::ES_IDLE && start) begin
      load_r <= load;
      cand_r <= cand_i;
      m_r    <= m_in;
      dx_r   <= (W+1)'(cand_i.cx) - (W+1)'(ref_i.cx);
      dy_r   <= (W+1)'(cand_i.cy) - (W+1)'(ref_i.cy);
      dz_r   <= (W+1)'(cand_i.cz) - (W+1)'(ref_i.cz);
    end
  end

  assign done   = (state_r == obbo_pkg::ES_DONE);
  assign rsp    = rsp_r;
  assign gate_o = gate_r;

endmodule

>>> src/obb_neighbor_overlap_sweep_unit.sv
// Oriented-box overlap sweep against one stored reference box.
// Input channel in_valid / in_stall / in_data carries requests: op = load
// stores the reference box, op = test checks a candidate against it.
// Result channel out_valid / out_stall / out_data returns one result per
// request; cfg_valid / cfg_ready / cfg_data writes miss_limit (always ready).
// A load runs one multiply in the engine; a test whose search is already
// over bypasses the engine. A test runs three squaring steps and a gate check,
// then up to four separating-axis passes of fourteen multiplies each, each
// multiply passing through a multiply state and an accumulate state on the
// single shared multiplier; the gate or the vertical test can reject early.
// in_stall is high from acceptance until the result enters the output
// register; one request is in flight at a time.
// A finished result waits in the engine while out_stall holds the output
// register full; the output register frees for the next request as soon
// as its contents are taken.
// Reset clears the reference box, the gate range, the miss count and the
// done flag, and sets miss_limit to 25.
module obb_neighbor_overlap_sweep_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  obbo_pkg::in_req_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output obbo_pkg::out_rsp_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [obbo_pkg::LIMIT_W-1:0]  cfg_data
);

  obbo_pkg::top_state_t state_r, state_nxt;

  obbo_pkg::box_t                   ref_r;
  logic [obbo_pkg::GATE_W-1:0]      gate_r;
  logic [obbo_pkg::MISS_W-1:0]      miss_r, miss_inc;
  logic                             over_r;
  logic [obbo_pkg::LIMIT_W-1:0]     limit_r;
  logic                             op_r;
  logic                             out_valid_r;
  obbo_pkg::out_rsp_t               out_data_r, rsp_nxt;

  obbo_pkg::box_t                   cand_box;
  logic                             in_acc, out_free, commit, eng_start, eng_done;
  logic                             miss_over;
  obbo_pkg::eng_rsp_t               eng_rsp;
  logic [obbo_pkg::GATE_W-1:0]      eng_gate;

  assign cand_box  = obbo_pkg::to_box(in_data);
  assign in_stall  = (state_r != obbo_pkg::TS_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Tests after the search has ended bypass the engine
  assign eng_start = in_acc && !(in_data.op == obbo_pkg::OP_TEST && over_r);

  obbo_sat_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (eng_start),
    .load   (in_data.op == obbo_pkg::OP_LOAD),
    .cand_i (cand_box),
    .ref_i  (ref_r),
    .gate_i (gate_r),
    .take   (commit),
    .done   (eng_done),
    .rsp    (eng_rsp),
    .gate_o (eng_gate)
  );

  assign miss_inc  = miss_r + obbo_pkg::MISS_W'(1);
  assign miss_over = miss_inc > obbo_pkg::MISS_W'(limit_r);

  // Next state and result assembly
  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    rsp_nxt   = '0;
    case (state_r)
      obbo_pkg::TS_IDLE: begin
        if (in_acc) state_nxt = eng_start ? obbo_pkg::TS_RUN : obbo_pkg::TS_QUICK;
      end
      obbo_pkg::TS_RUN: begin
        if (eng_done && out_free) begin
          commit    = 1'b1;
          state_nxt = obbo_pkg::TS_IDLE;
        end
        if (op_r == obbo_pkg::OP_TEST) begin
          rsp_nxt.overlap      = eng_rsp.overlap && !eng_rsp.out_of_range;
          rsp_nxt.out_of_range = eng_rsp.out_of_range;
          rsp_nxt.search_done  = eng_rsp.out_of_range && miss_over;
        end
      end
      obbo_pkg::TS_QUICK: begin
        rsp_nxt.search_done = 1'b1;
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = obbo_pkg::TS_IDLE;
        end
      end
      default: state_nxt = obbo_pkg::TS_IDLE;
    endcase
  end

  // Control and reference state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= obbo_pkg::TS_IDLE;
      ref_r       <= '0;
      gate_r      <= '0;
      miss_r      <= '0;
      over_r      <= 1'b0;
      limit_r     <= obbo_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
      if (in_acc && in_data.op == obbo_pkg::OP_LOAD) begin
        ref_r  <= cand_box;
        miss_r <= '0;
        over_r <= 1'b0;
      end
      if (commit && state_r == obbo_pkg::TS_RUN) begin
        if (op_r == obbo_pkg::OP_LOAD) begin
          gate_r <= eng_gate;
        end else if (eng_rsp.out_of_range) begin
          miss_r <= miss_inc;
          over_r <= miss_over;
        end else begin
          miss_r <= '0;
        end
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request opcode and result payload
  always_ff @(posedge clk) begin
    if (in_acc) op_r <= in_data.op;
    if (commit) out_data_r <= rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A miss result never claims an overlap
  a_no_overlap_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.overlap && out_data.out_of_range))
    else $error("overlap reported together with out_of_range");

  // The engine only finishes while a request is running
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    eng_done |-> state_r == obbo_pkg::TS_RUN)
    else $error("engine finished outside a running request");

  // The search ends only together with a result that says so
  a_over_reported: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(over_r) |-> out_valid && out_data.search_done)
    else $error("search ended without a search_done result");

  // The engine neither starts nor finishes while a bypassed test is pending
  a_quick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == obbo_pkg::TS_QUICK |-> !eng_start && !eng_done)
    else $error("engine active during a bypassed test");

endmodule
